// File: rtl/core/vha_pkg.sv
// Shared constants, codes and types of the versioned handle allocator.
`default_nettype none

package vha_pkg;

    // Handle layout: slot id in the low bits, generation above it.
    localparam int ID_BITS     = 10;
    localparam int GEN_BITS    = 6;
    localparam int HANDLE_BITS = ID_BITS + GEN_BITS;
    localparam int USED_BITS   = ID_BITS + 1;

    // Fixed field widths of the stream payloads.
    localparam int ACTION_W = 3;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 10;

    localparam int IN_FIELDS_W  = ACTION_W + 2 * HANDLE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = HANDLE_W + 1 + STATUS_W + LIVE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ID_BITS-1:0]     NULL_ID     = '1;
    localparam logic [HANDLE_BITS-1:0] NULL_HANDLE = '1;

    localparam logic [ACTION_W-1:0] ACT_CREATE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DESTROY     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_PARENT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_PARENT = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } vha_state_t;

    // One memory's access request for a cycle.
    typedef struct packed {
        logic                   rd_en;
        logic [ID_BITS-1:0]     rd_addr;
        logic                   wr_en;
        logic [ID_BITS-1:0]     wr_addr;
        logic [HANDLE_BITS-1:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/vha_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module vha_ram #(
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/vha_ctrl.sv
// Sequencer and read-modify-write datapath of the handle allocator.
`default_nettype none

module vha_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [vha_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [vha_pkg::OUT_DATA_W-1:0]    m_tdata,
    output vha_pkg::mem_req_t                      slot_req,
    output vha_pkg::mem_req_t                      parent_req,
    input  wire logic [vha_pkg::HANDLE_BITS-1:0]   slot_rdata,
    input  wire logic [vha_pkg::HANDLE_BITS-1:0]   parent_rdata
);

    localparam int IDB = vha_pkg::ID_BITS;
    localparam int HB  = vha_pkg::HANDLE_BITS;
    localparam int UB  = vha_pkg::USED_BITS;

    vha_pkg::vha_state_t state_reg, state_next;

    logic [vha_pkg::ACTION_W-1:0]   act_reg;
    logic [vha_pkg::HANDLE_W-1:0]   hdl_reg;
    logic [vha_pkg::HANDLE_W-1:0]   par_reg;
    logic [IDB-1:0]                 free_head_reg, free_head_next;
    logic [UB-1:0]                  slots_used_reg, slots_used_next;
    logic [vha_pkg::LIVE_W-1:0]     live_reg, live_next;
    logic                           m_valid_reg;
    logic [vha_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                           accept;
    logic                           commit;
    logic [vha_pkg::ACTION_W-1:0]   in_action;
    logic [vha_pkg::HANDLE_W-1:0]   in_handle;
    logic [vha_pkg::HANDLE_W-1:0]   in_parent;

    logic [IDB-1:0]                 id;
    logic [vha_pkg::GEN_BITS-1:0]   gen_inc;
    logic                           bad;
    logic [vha_pkg::HANDLE_W-1:0]   res;
    logic                           flag;
    logic [vha_pkg::STATUS_W-1:0]   status;
    logic                           slot_we, parent_we;
    logic [IDB-1:0]                 wr_addr;
    logic [HB-1:0]                  slot_wdata, parent_wdata;

    assign in_action = s_tdata[vha_pkg::ACTION_W-1:0];
    assign in_handle = s_tdata[vha_pkg::ACTION_W +: vha_pkg::HANDLE_W];
    assign in_parent = s_tdata[vha_pkg::ACTION_W + vha_pkg::HANDLE_W +: vha_pkg::HANDLE_W];

    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = vha_pkg::ST_EXEC;
                end
            end
            vha_pkg::ST_EXEC:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = vha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vha_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            vha_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            vha_pkg::ST_EXEC:
            begin
                commit = !m_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // The slot read issued at acceptance is back; work out the result and the write.
    always_comb
    begin
        id              = hdl_reg[IDB-1:0];
        gen_inc         = hdl_reg[HB-1:IDB] + 1'b1;
        bad             = (id == vha_pkg::NULL_ID) || ({1'b0, id} >= slots_used_reg);
        res             = '0;
        flag            = 1'b0;
        status          = vha_pkg::STAT_OK;
        slot_we         = 1'b0;
        parent_we       = 1'b0;
        wr_addr         = id;
        slot_wdata      = '0;
        parent_wdata    = vha_pkg::NULL_HANDLE;
        free_head_next  = free_head_reg;
        slots_used_next = slots_used_reg;
        live_next       = live_reg;
        if (act_reg == vha_pkg::ACT_CREATE)
        begin
            if (free_head_reg != vha_pkg::NULL_ID)
            begin
                // Reuse the head of the free list with its stored generation.
                wr_addr          = free_head_reg;
                slot_wdata       = {slot_rdata[HB-1:IDB], free_head_reg};
                free_head_next   = slot_rdata[IDB-1:0];
                slot_we          = 1'b1;
                parent_we        = 1'b1;
                live_next        = live_reg + 1'b1;
                res[HB-1:0]      = slot_wdata;
            end
            else if (slots_used_reg < {1'b0, vha_pkg::NULL_ID})
            begin
                wr_addr          = slots_used_reg[IDB-1:0];
                slot_wdata       = '0;
                slot_wdata[IDB-1:0] = slots_used_reg[IDB-1:0];
                slot_we          = 1'b1;
                parent_we        = 1'b1;
                slots_used_next  = slots_used_reg + 1'b1;
                live_next        = live_reg + 1'b1;
                res[HB-1:0]      = slot_wdata;
            end
            else
            begin
                status = vha_pkg::STAT_FULL;
            end
        end
        else if (act_reg <= vha_pkg::ACT_READ_PARENT)
        begin
            if (bad)
            begin
                status = vha_pkg::STAT_BAD;
            end
            else
            begin
                case (act_reg)
                    vha_pkg::ACT_DESTROY:
                    begin
                        slot_wdata     = {gen_inc, free_head_reg};
                        slot_we        = 1'b1;
                        free_head_next = id;
                        live_next      = live_reg - 1'b1;
                    end
                    vha_pkg::ACT_CHECK:
                    begin
                        flag = (slot_rdata[IDB-1:0] == id);
                    end
                    vha_pkg::ACT_SET_PARENT:
                    begin
                        parent_wdata = par_reg[HB-1:0];
                        parent_we    = 1'b1;
                    end
                    vha_pkg::ACT_READ_PARENT:
                    begin
                        res[HB-1:0] = parent_rdata;
                        flag        = (parent_rdata[IDB-1:0] != vha_pkg::NULL_ID);
                    end
                    default:
                    begin
                        flag = 1'b0;
                    end
                endcase
            end
        end

        m_data_next = '0;
        m_data_next[vha_pkg::HANDLE_W-1:0] = res;
        m_data_next[vha_pkg::HANDLE_W] = flag;
        m_data_next[vha_pkg::HANDLE_W + 1 +: vha_pkg::STATUS_W] = status;
        m_data_next[vha_pkg::HANDLE_W + 1 + vha_pkg::STATUS_W +: vha_pkg::LIVE_W] = live_next;
    end

    // Memory requests: reads at acceptance, writes at commit.
    always_comb
    begin
        slot_req.rd_en   = accept;
        slot_req.rd_addr = (in_action == vha_pkg::ACT_CREATE) ? free_head_reg
                                                              : in_handle[IDB-1:0];
        slot_req.wr_en   = commit && slot_we;
        slot_req.wr_addr = wr_addr;
        slot_req.wr_data = slot_wdata;

        parent_req.rd_en   = accept;
        parent_req.rd_addr = slot_req.rd_addr;
        parent_req.wr_en   = commit && parent_we;
        parent_req.wr_addr = wr_addr;
        parent_req.wr_data = parent_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vha_pkg::ST_IDLE;
            free_head_reg  <= vha_pkg::NULL_ID;
            slots_used_reg <= '0;
            live_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                free_head_reg  <= free_head_next;
                slots_used_reg <= slots_used_next;
                live_reg       <= live_next;
                m_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= in_action;
            hdl_reg <= in_handle;
            par_reg <= in_parent;
        end
        if (commit)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/versioned_handle_allocator_unit.sv
// Top level of the versioned handle allocator: sequencer and the two slot memories.
//
// Each request passes the idle and execute states: in the cycle it is accepted the slot
// and parent memories are read at the addressed slot (or at the free-list head for
// create), and in the execute state the entry is modified, written back and the answer
// loaded into the output register once that register is free. Only then does the block
// return to idle and take a new request, so it holds one request at a time, as set by
// the registered read of the memories and by the free-list head, which each create and
// destroy must update before the next request can use it. A stalled result holds the
// block in its execute state. The memories are not cleared after reset: entries are
// only used once they have been written, so the block is ready straight out of reset.
`default_nettype none

module versioned_handle_allocator_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: action[3], handle[16], parent_handle[16], zero fill.
    input  wire logic [vha_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // Fields from bit 0: result_handle[16], flag[1], status[2], live_count[10], zero fill.
    output logic      [vha_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    vha_pkg::mem_req_t                slot_req;
    vha_pkg::mem_req_t                parent_req;
    logic [vha_pkg::HANDLE_BITS-1:0]  slot_rdata;
    logic [vha_pkg::HANDLE_BITS-1:0]  parent_rdata;

    vha_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .slot_req     (slot_req),
        .parent_req   (parent_req),
        .slot_rdata   (slot_rdata),
        .parent_rdata (parent_rdata)
    );

    vha_ram #(
        .WIDTH (vha_pkg::HANDLE_BITS),
        .AW    (vha_pkg::ID_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_req.wr_en),
        .wr_addr (slot_req.wr_addr),
        .wr_data (slot_req.wr_data),
        .rd_en   (slot_req.rd_en),
        .rd_addr (slot_req.rd_addr),
        .rd_data (slot_rdata)
    );

    vha_ram #(
        .WIDTH (vha_pkg::HANDLE_BITS),
        .AW    (vha_pkg::ID_BITS)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (parent_req.wr_en),
        .wr_addr (parent_req.wr_addr),
        .wr_data (parent_req.wr_data),
        .rd_en   (parent_req.rd_en),
        .rd_addr (parent_req.rd_addr),
        .rd_data (parent_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/vha_checker.sv
// Port-level checks of the handle allocator, bound to the top level.
`default_nettype none

module vha_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [vha_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int STAT_LSB = vha_pkg::HANDLE_W + 1;

    logic [vha_pkg::STATUS_W-1:0] out_status;
    logic                         in_xfer;

    assign out_status = m_axis_tdata[STAT_LSB +: vha_pkg::STATUS_W];
    assign in_xfer    = s_axis_tvalid && s_axis_tready;

    // A result stays offered until its transfer completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result withdrawn or changed while stalled");

    // One request at a time: no new request in the cycle after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    // Status code three is never produced.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_status != 2'd3)
        else $error("undefined status code");

    // An error answer carries zero handle and flag.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_status == vha_pkg::STAT_FULL || out_status == vha_pkg::STAT_BAD)
        |-> m_axis_tdata[vha_pkg::HANDLE_W:0] == '0)
        else $error("error answer with non-zero payload");

endmodule

bind versioned_handle_allocator_unit vha_checker u_vha_checker (.*);

`default_nettype wire

// File: verif/vha_alloc_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the versioned handle allocator: predicts each answer and compares it.
module vha_alloc_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_tvalid,
    input  wire logic                           req_tready,
    // Fields from bit 0: action[3], handle[16], parent_handle[16], zero fill.
    input  wire logic [vha_pkg::IN_DATA_W-1:0]  req_tdata,
    input  wire logic                           rsp_tvalid,
    input  wire logic                           rsp_tready,
    // Fields from bit 0: result_handle[16], flag[1], status[2], live_count[10], zero fill.
    input  wire logic [vha_pkg::OUT_DATA_W-1:0] rsp_tdata,
    output int                                  fail_count,
    output int                                  pending
);
    import vha_pkg::*;

    localparam int SLOTS = 1 << ID_BITS;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                flag;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live;
    } answer_t;

    // Shadow copy of the slot table, free list and counters.
    logic [HANDLE_BITS-1:0] slot_mem   [0:SLOTS-1];
    logic [HANDLE_BITS-1:0] parent_mem [0:SLOTS-1];
    logic [ID_BITS-1:0]     free_head;
    logic [USED_BITS-1:0]   slots_used;
    logic [LIVE_W-1:0]      live_total;

    answer_t awaited_answers[$];
    answer_t want;
    answer_t got;
    int      mismatches = 0;
    int      queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    function automatic answer_t alloc_step(input logic [ACTION_W-1:0] act,
                                           input logic [HANDLE_W-1:0] hnd,
                                           input logic [HANDLE_W-1:0] par);
        answer_t                a;
        logic [ID_BITS-1:0]     id;
        logic [ID_BITS-1:0]     cur;
        logic [HANDLE_BITS-1:0] w;
        logic                   bad;
        a   = '0;
        id  = hnd[ID_BITS-1:0];
        bad = (id == NULL_ID) || ({1'b0, id} >= slots_used);
        case (act)
            ACT_CREATE:
            begin
                if (free_head != NULL_ID)
                begin
                    // Reuse the head of the free list with the generation stored there.
                    cur       = free_head;
                    w         = slot_mem[cur];
                    free_head = w[ID_BITS-1:0];
                    a.handle  = {w[HANDLE_BITS-1:ID_BITS], cur};
                    slot_mem[cur]   = a.handle;
                    parent_mem[cur] = NULL_HANDLE;
                    live_total = live_total + 1'b1;
                end
                else if (slots_used < USED_BITS'(NULL_ID))
                begin
                    cur      = slots_used[ID_BITS-1:0];
                    a.handle = {GEN_BITS'(0), cur};
                    slot_mem[cur]   = a.handle;
                    parent_mem[cur] = NULL_HANDLE;
                    slots_used = slots_used + 1'b1;
                    live_total = live_total + 1'b1;
                end
                else
                begin
                    a.status = STAT_FULL;
                end
            end
            ACT_DESTROY, ACT_CHECK, ACT_SET_PARENT, ACT_READ_PARENT:
            begin
                if (bad)
                begin
                    a.status = STAT_BAD;
                end
                else if (act == ACT_DESTROY)
                begin
                    slot_mem[id] = {hnd[HANDLE_BITS-1:ID_BITS] + GEN_BITS'(1), free_head};
                    free_head    = id;
                    live_total   = live_total - 1'b1;
                end
                else if (act == ACT_CHECK)
                begin
                    a.flag = (slot_mem[id][ID_BITS-1:0] == id);
                end
                else if (act == ACT_SET_PARENT)
                begin
                    parent_mem[id] = par;
                end
                else
                begin
                    a.handle = parent_mem[id];
                    a.flag   = (parent_mem[id][ID_BITS-1:0] != NULL_ID);
                end
            end
            default:
            begin
            end
        endcase
        a.live = live_total;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head  = NULL_ID;
            slots_used = '0;
            live_total = '0;
            awaited_answers.delete();
            queued = 0;
        end
        else
        begin
            if (req_tvalid && req_tready)
            begin
                awaited_answers.push_back(alloc_step(req_tdata[ACTION_W-1:0],
                                                     req_tdata[ACTION_W +: HANDLE_W],
                                                     req_tdata[ACTION_W+HANDLE_W +: HANDLE_W]));
            end
            if (rsp_tvalid && rsp_tready)
            begin
                got.handle = rsp_tdata[HANDLE_W-1:0];
                got.flag   = rsp_tdata[HANDLE_W];
                got.status = rsp_tdata[HANDLE_W+1 +: STATUS_W];
                got.live   = rsp_tdata[HANDLE_W+1+STATUS_W +: LIVE_W];
                if (awaited_answers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with none awaited: expected nothing, ",
                             $time, "actual handle %h flag %b status %0d live %0d",
                             got.handle, got.flag, got.status, got.live);
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: expected handle %h flag %b status %0d live %0d, ",
                                 $time, want.handle, want.flag, want.status, want.live,
                                 "actual handle %h flag %b status %0d live %0d",
                                 got.handle, got.flag, got.status, got.live);
                    end
                end
            end
            queued = awaited_answers.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top of the versioned handle allocator: stimulus, idling and the verdict.
module tb_top;
    import vha_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 120;
    localparam int FILL_CAP       = 1100;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int  fail_count;
    int  pending;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    bit  saw_full = 0;
    int  idle_cycles = 0;

    // Actions in flight, and the handles the stimulus believes live or destroyed.
    logic [ACTION_W-1:0] actions_in_flight[$];
    logic [HANDLE_W-1:0] live_handles[$];
    logic [HANDLE_W-1:0] dead_handles[$];
    logic [ACTION_W-1:0] done_action;
    logic [HANDLE_W-1:0] victim;

    versioned_handle_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    vha_alloc_checker u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_tvalid (s_axis_tvalid),
        .req_tready (s_axis_tready),
        .req_tdata  (s_axis_tdata),
        .rsp_tvalid (m_axis_tvalid),
        .rsp_tready (m_axis_tready),
        .rsp_tdata  (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Receiver: random stalls, plus one long hold-off counted here when requested.
    initial
    begin : receiver
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req      = 0;
                hold_left     = HOLD_CYCLES;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Learns the handles that creates hand out, so later items can use them.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && actions_in_flight.size() > 0)
        begin
            done_action = actions_in_flight.pop_front();
            if (done_action == ACT_CREATE)
            begin
                if (m_axis_tdata[HANDLE_W+1 +: STATUS_W] == STAT_OK)
                    live_handles.push_back(m_axis_tdata[HANDLE_W-1:0]);
                else if (m_axis_tdata[HANDLE_W+1 +: STATUS_W] == STAT_FULL)
                    saw_full = 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("versioned_handle_allocator_unit verification failed");
            $finish;
        end
    end

    task automatic send_op(input logic [ACTION_W-1:0] act,
                           input logic [HANDLE_W-1:0] hnd,
                           input logic [HANDLE_W-1:0] par);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = IN_DATA_W'({par, hnd, act});
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        actions_in_flight.push_back(act);
    endtask

    // Stops offering items and waits until every answer has come back.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (live_handles.size() > 0 && r < 70)
            return live_handles[$urandom_range(live_handles.size() - 1)];
        else if (live_handles.size() > 0 && r < 80)
            return {GEN_BITS'($urandom),
                    live_handles[$urandom_range(live_handles.size() - 1)][ID_BITS-1:0]};
        else if (r < 90)
            return {GEN_BITS'($urandom), NULL_ID};
        else
            return HANDLE_W'($urandom);
    endfunction

    // Before the table is filled no slot is destroyed twice, so the free list
    // stays intact and the full table can still be reached.
    task automatic random_op(input bit allow_stale);
        int                  r;
        int                  k;
        logic [HANDLE_W-1:0] hnd;
        logic [HANDLE_W-1:0] par;
        r   = $urandom_range(99);
        k   = $urandom_range(99);
        hnd = pick_handle();
        if (k < 40 && live_handles.size() > 0)
            par = live_handles[$urandom_range(live_handles.size() - 1)];
        else if (k < 70)
            par = HANDLE_W'($urandom);
        else if (k < 85)
            par = NULL_HANDLE;
        else
            par = {GEN_BITS'($urandom), NULL_ID};
        if (r < 30)
        begin
            send_op(ACT_CREATE, HANDLE_W'($urandom), par);
        end
        else if (r < 50)
        begin
            if (live_handles.size() > 0 && (allow_stale ? (k < 70) : (k < 90)))
            begin
                k   = $urandom_range(live_handles.size() - 1);
                hnd = live_handles[k];
                live_handles.delete(k);
                dead_handles.push_back(hnd);
            end
            else if (allow_stale && dead_handles.size() > 0 && k < 85)
                hnd = dead_handles[$urandom_range(dead_handles.size() - 1)];
            else if (allow_stale)
                hnd = HANDLE_W'($urandom);
            else
                hnd = {GEN_BITS'($urandom), NULL_ID};
            send_op(ACT_DESTROY, hnd, par);
        end
        else if (r < 65)
            send_op(ACT_CHECK, hnd, par);
        else if (r < 78)
            send_op(ACT_SET_PARENT, hnd, par);
        else if (r < 93)
            send_op(ACT_READ_PARENT, hnd, par);
        else
            send_op(ACTION_W'($urandom_range(7, 5)), HANDLE_W'($urandom), par);
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input bit allow_stale, input bit with_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == 20)
                hold_req = 1;
            random_op(allow_stale);
        end
    endtask

    initial
    begin : stimulus
        int fill_count;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: every handle is out of range; unused actions answer zeros.
        send_op(ACT_CHECK, 16'h0000, 16'h0000);
        send_op(ACT_DESTROY, 16'h0000, 16'hFFFF);
        send_op(ACT_READ_PARENT, 16'h0000, 16'h0000);
        send_op(ACT_SET_PARENT, 16'h0000, 16'hFFFF);
        send_op(3'd5, 16'hFFFF, 16'hFFFF);
        send_op(ACT_CREATE, 16'hFFFF, 16'hFFFF);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        // The check compares ids only, so a wrong generation still reads live.
        send_op(ACT_CHECK, 16'h0001, 16'h0000);
        send_op(ACT_CHECK, 16'hFC01, 16'h0000);
        send_op(ACT_CHECK, 16'h0003, 16'h0000);
        send_op(ACT_CHECK, 16'hFFFF, 16'h0000);
        send_op(ACT_READ_PARENT, 16'h0001, 16'h0000);
        send_op(ACT_SET_PARENT, 16'h0001, 16'h0000);
        send_op(ACT_READ_PARENT, 16'h0001, 16'hFFFF);
        send_op(ACT_SET_PARENT, 16'h0002, 16'hFFFE);
        send_op(ACT_DESTROY, 16'h0001, 16'h0000);
        send_op(ACT_CHECK, 16'h0001, 16'h0000);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        send_op(ACT_READ_PARENT, 16'h0401, 16'h0000);
        // Destroy with the top generation, which wraps back to zero.
        send_op(ACT_DESTROY, 16'hFC02, 16'h0000);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        send_op(3'd7, 16'h0000, 16'h0000);
        send_op(3'd6, 16'hFFFF, 16'h0000);
        wait_drained();
        live_handles = '{16'h0000, 16'h0401, 16'h0002};
        dead_handles.delete();

        run_phase(140, 0, 0, 0, 1);
        run_phase(140, 61, 0, 0, 0);

        // Fill every slot until the table reports full, then probe it there.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_count     = 0;
        while (!saw_full && fill_count < FILL_CAP)
        begin
            send_op(ACT_CREATE, HANDLE_W'($urandom), HANDLE_W'($urandom));
            fill_count++;
        end
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        send_op(ACT_CREATE, 16'hFFFF, 16'hFFFF);
        send_op(ACT_CHECK, {GEN_BITS'($urandom), NULL_ID}, 16'h0000);
        send_op(ACT_CHECK, 16'd1022, 16'h0000);
        wait_drained();

        // A double destroy makes the slot point at itself, so creates keep
        // succeeding past a full table and the live count wraps to zero.
        victim = live_handles[0];
        live_handles.delete(0);
        dead_handles.push_back(victim);
        send_op(ACT_DESTROY, victim, 16'h0000);
        send_op(ACT_DESTROY, victim, 16'h0000);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);
        send_op(ACT_CREATE, 16'h0000, 16'h0000);

        run_phase(135, 0, 61, 1, 0);
        run_phase(135, 24, 24, 1, 0);

        recv_stall_pct = 0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("versioned_handle_allocator_unit verification clean");
        else
            $display("versioned_handle_allocator_unit verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/vha_pkg.sv
rtl/core/vha_ram.sv
rtl/core/vha_ctrl.sv
rtl/core/versioned_handle_allocator_unit.sv
rtl/core/vha_checker.sv
verif/vha_alloc_checker.sv
verif/tb_top.sv
